[rtl/sha256sh_pkg.sv]
// ----------------------------------------------------------------------------
// sha256sh_pkg
// Shared types, round constants and initial hash values of the SHA-256
// stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256sh_pkg;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned DIGEST_WORDS = 8;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LAST_FILL = 6'(BLOCK_BYTES - 1);
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX = 3'(DIGEST_WORDS - 1);
   localparam logic [2:0] LEN_SLOT = 3'b111;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_data_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      BYTE_DATA,
      BYTE_MARK,
      BYTE_ZERO,
      BYTE_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type byte_sel;
      logic [2:0]   len_idx;
      logic         count_byte;
      logic         load_work;
      logic         round_en;
      logic [5:0]   round_idx;
      logic         add_hash;
      logic         clear_msg;
      logic [2:0]   word_idx;
   } dp_cmd_type;

endpackage

`default_nettype wire

[rtl/sha256sh_ctrl.sv]
// ----------------------------------------------------------------------------
// sha256sh_ctrl
// Sequencer: byte intake, padding, compression rounds and digest readout.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256sh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    byte_present,
   input  logic                    end_of_message,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              word_index,
   output logic                    last_word,
   output sha256sh_pkg::dp_cmd_type cmd
);
   import sha256sh_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       pad_ff, pad_in;
   logic       mark_ff, mark_in;
   logic       final_ff, final_in;
   logic       accept;
   logic [5:0] fill_step;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign fill_step = fill_ff + 6'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      word_in  = word_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      final_in = final_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (byte_present) begin
                  fill_in = fill_step;
               end
               if (end_of_message) begin
                  pad_in   = 1'b1;
                  mark_in  = 1'b0;
                  final_in = (fill_in[5:3] != LEN_SLOT);
               end
               if (byte_present && (fill_ff == LAST_FILL)) begin
                  state_in = ST_LOAD;
               end else if (end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            fill_in = fill_step;
            mark_in = 1'b1;
            if (fill_ff == LAST_FILL) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            priority if (!pad_ff) begin
               state_in = ST_IDLE;
            end else if (mark_ff && final_ff) begin
               word_in  = '0;
               state_in = ST_OUT;
            end else if (mark_ff) begin
               final_in = 1'b1;
               state_in = ST_PAD;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (word_ff == LAST_WORD_IDX) begin
                  pad_in   = 1'b0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.byte_sel  = BYTE_DATA;
      cmd.len_idx   = fill_ff[2:0];
      cmd.round_idx = round_ff;
      cmd.word_idx  = word_ff;
      req_stall     = (state_ff != ST_IDLE);
      rsp_valid     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.shift_en   = accept && byte_present;
            cmd.count_byte = accept && byte_present;
         end
         ST_PAD: begin
            cmd.shift_en = 1'b1;
            priority if (!mark_ff) begin
               cmd.byte_sel = BYTE_MARK;
            end else if (final_ff && (fill_ff[5:3] == LEN_SLOT)) begin
               cmd.byte_sel = BYTE_LEN;
            end else begin
               cmd.byte_sel = BYTE_ZERO;
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
         end
         ST_UPDATE: begin
            cmd.add_hash = 1'b1;
         end
         ST_OUT: begin
            rsp_valid     = 1'b1;
            cmd.clear_msg = !rsp_stall && (word_ff == LAST_WORD_IDX);
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign word_index = word_ff;
   assign last_word  = (word_ff == LAST_WORD_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         round_ff <= '0;
         word_ff  <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         final_ff <= final_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sha256sh_datapath.sv]
// ----------------------------------------------------------------------------
// sha256sh_datapath
// Block buffer and message schedule window, round unit, hash state and
// message bit length.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256sh_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sha256sh_pkg::dp_cmd_type cmd,
   input  logic [7:0]               data_byte,
   output logic [31:0]              digest_word
);
   import sha256sh_pkg::*;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // win_ff[0] is the oldest word; bytes enter at the low byte of win_ff[15]
   logic [0:15][31:0] win_ff, win_in;
   logic [31:0]       work_ff [8];
   logic [31:0]       work_in [8];
   logic [31:0]       hash_ff [8];
   logic [31:0]       hash_in [8];
   logic [60:0]       total_ff, total_in;
   logic [63:0]       bit_len;
   logic [7:0]        len_byte;
   logic [7:0]        shift_byte;
   logic [31:0]       t1, t2, w_new;

   assign bit_len  = {total_ff, 3'b000};
   assign len_byte = 8'(bit_len >> {~cmd.len_idx, 3'b000});

   always_comb begin
      unique case (cmd.byte_sel)
         BYTE_DATA: shift_byte = data_byte;
         BYTE_MARK: shift_byte = PAD_MARK;
         BYTE_ZERO: shift_byte = 8'h00;
         BYTE_LEN:  shift_byte = len_byte;
         default:   shift_byte = 8'h00;
      endcase
   end

   assign t1 = work_ff[7] + big_sig1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + ROUND_K[cmd.round_idx] + win_ff[0];
   assign t2 = big_sig0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));
   assign w_new = small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];

   always_comb begin
      win_in   = win_ff;
      work_in  = work_ff;
      hash_in  = hash_ff;
      total_in = total_ff;
      if (cmd.shift_en) begin
         win_in = {win_ff[0][23:0], win_ff[1:15], shift_byte};
      end
      if (cmd.count_byte) begin
         total_in = total_ff + 61'd1;
      end
      if (cmd.load_work) begin
         work_in = hash_ff;
      end
      if (cmd.round_en) begin
         win_in     = {win_ff[1:15], w_new};
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
      if (cmd.add_hash) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
      if (cmd.clear_msg) begin
         hash_in  = INIT_H;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= INIT_H;
         total_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
   end

   assign digest_word = hash_ff[cmd.word_idx];

endmodule

`default_nettype wire

[rtl/sha256_stream_hasher_top.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream; eight digest words per message.
// ----------------------------------------------------------------------------
// Input channel req_*: one transfer carries one message byte (byte_present)
// and/or the end flag (end_of_message). A transfer with neither flag is a
// no-op. A transfer with only end_of_message closes a message without a byte.
// Output channel rsp_*: eight transfers per message, digest word 0 (most
// significant) first, last_word set on word 7.
// Intake: one byte per cycle while a block fills; the 64th byte starts a
// compression (load, 64 rounds, hash update) during which req_stall is high.
// After the end transfer the last block is padded out to 64 bytes and
// compressed; when 56 or more bytes sit in the last block, a second padding
// block and compression follow. Then the digest words, one per cycle while
// rsp_stall is low.
// No input is taken while the digest is offered; rsp_stall holds the current
// word. After word 7 transfers the hash state returns to the initial values.
// Reset (synchronous) clears the sequencer, byte count and hash state.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sha256sh_pkg::req_data_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sha256sh_pkg::rsp_data_type rsp_data
);
   import sha256sh_pkg::*;

   dp_cmd_type  cmd;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   sha256sh_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .byte_present   (req_data.byte_present),
      .end_of_message (req_data.end_of_message),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .word_index     (word_index),
      .last_word      (last_word),
      .cmd            (cmd)
   );

   sha256sh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data.data_byte),
      .digest_word (digest_word)
   );

   assign rsp_data.digest_word = digest_word;
   assign rsp_data.word_index  = word_index;
   assign rsp_data.last_word   = last_word;

   a_no_intake_during_output: assert property (
      @(posedge clock) disable iff (reset) rsp_valid |-> req_stall
   ) else $error("input taken while digest offered");

   a_last_word_ends_output: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_word) |=> !rsp_valid
   ) else $error("output continued after last word");

   a_word_advance: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_word) |=>
         (rsp_valid && (rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
   ) else $error("digest word order broken");

endmodule

`default_nettype wire
